// ===== design/lspc_pkg.sv =====
`timescale 1ns / 1ps

package lspc_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FEW      = 2'd1;
  localparam logic [1:0] STATUS_SINGULAR = 2'd2;

  // Datapath widths
  localparam int ACC_W   = 64;
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 25;
  localparam int DEN_W   = 48;
  localparam int DT_W    = 19;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 2;

  // Input tdata, last declared field (meas_x) in the lowest bits
  typedef struct packed {
    logic signed [15:0] pose_sin;
    logic signed [15:0] pose_cos;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_x;
    logic        [15:0] pair_error;
    logic signed [15:0] nom_y;
    logic signed [15:0] nom_x;
    logic signed [15:0] meas_y;
    logic signed [15:0] meas_x;
  } in_data_t;

  // Output tdata, last declared field (new_x) in the lowest bits
  typedef struct packed {
    logic        [4:0]      pad;
    logic        [15:0]     max_error;
    logic signed [DT_W-1:0] delta_heading;
    logic signed [15:0]     new_y;
    logic signed [15:0]     new_x;
  } out_data_t;

endpackage

// ===== design/least_squares_pose_correction_unit.sv =====
`timescale 1ns / 1ps
// A pair that is not last runs four products through the shared multiplier (a multiply
// state and an add state each) plus entry and check; a pair past MAX_PAIRS skips the products.
// A last pair adds further products and three divisions on one shared restoring divider.
// The input is not ready while a pair is in work, so one pair must finish before the next is taken.
// Reset (rst_ni low, asynchronous) clears all sums, the count and the output valid.
module least_squares_pose_correction_unit
  import lspc_pkg::*;
#(
  parameter int MAX_PAIRS = 64,
  parameter int MIN_PAIRS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // meas_x, meas_y, nom_x, nom_y, pair_error, pose_x, pose_y, pose_cos, pose_sin
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // last_pair
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // new_x, new_y, delta_heading, max_error, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DEND = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  // Multiply-accumulate steps
  localparam logic [3:0] OP_R_MX = 4'd0;
  localparam logic [3:0] OP_R_MY = 4'd1;
  localparam logic [3:0] OP_C_MX = 4'd2;
  localparam logic [3:0] OP_C_MY = 4'd3;
  localparam logic [3:0] OP_D_NR = 4'd4;
  localparam logic [3:0] OP_D_SX = 4'd5;
  localparam logic [3:0] OP_D_SY = 4'd6;
  localparam logic [3:0] OP_N_NC = 4'd7;
  localparam logic [3:0] OP_N_SY = 4'd8;
  localparam logic [3:0] OP_N_SX = 4'd9;
  localparam logic [3:0] OP_DX   = 4'd10;
  localparam logic [3:0] OP_DY   = 4'd11;
  localparam logic [3:0] OP_X_C  = 4'd12;
  localparam logic [3:0] OP_X_S  = 4'd13;
  localparam logic [3:0] OP_Y_S  = 4'd14;
  localparam logic [3:0] OP_Y_C  = 4'd15;

  localparam logic signed [ACC_W-1:0] RND_HALF   = 64'sd536870912;
  localparam logic signed [ACC_W-1:0] RND_HALF_M = 64'sd536870911;
  localparam logic [63:0] DT_POS_LIM = 64'd262143;
  localparam logic [63:0] DT_NEG_LIM = 64'd262144;

  logic [2:0]              state_q;
  logic [3:0]              op_q;
  in_data_t                in_q;
  logic                    last_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [23:0]      sum_mx_q, sum_my_q, sum_bx_q, sum_by_q;
  logic [39:0]             sum_r_q;
  logic signed [41:0]      sum_c_q;
  logic [15:0]             max_err_q;
  logic signed [ACC_W-1:0] mul_q, acc_q;
  logic [DEN_W-1:0]        den_q;
  logic                    neg_q;
  logic [48:0]             rem_q;
  logic [63:0]             quo_q;
  logic [5:0]              div_cnt_q;
  logic signed [DT_W-1:0]  dt_q;
  logic signed [47:0]      dxq_q, dyq_q;
  logic signed [15:0]      nx_q, ny_q;
  logic [1:0]              stat_q;
  logic                    m_valid_q;
  out_data_t               m_data_q;
  logic [1:0]              m_user_q;

  in_data_t                in_w;
  logic                    s_acc, take;
  logic signed [16:0]      bx, by;
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b, n_b;
  logic signed [MUL_A_W+MUL_B_W-1:0] prod;
  logic signed [ACC_W-1:0] base, acc_d;
  logic                    op_sub;
  logic [63:0]             acc_mag;
  logic [63:0]             dvd;
  logic [49:0]             trial;
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [33:0]      rnd_q;
  logic signed [15:0]      rnd_sat;
  logic signed [DT_W-1:0]  dt_sat;
  logic signed [63:0]      quo_s;
  logic                    few;

  assign in_w = in_data_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign take = (cnt_q < CNT_W'(MAX_PAIRS));
  assign few = (int'(cnt_q) < MIN_PAIRS);

  // Residuals of the stored pair
  assign bx = 17'(in_q.nom_x) - 17'(in_q.meas_x);
  assign by = 17'(in_q.nom_y) - 17'(in_q.meas_y);
  assign n_b = MUL_B_W'({1'b0, cnt_q});

  // Operand, base and sign select of the shared multiply-accumulate unit
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    base   = acc_q;
    op_sub = 1'b0;
    case (op_q)
      OP_R_MX: begin
        op_a = MUL_A_W'(in_q.meas_x); op_b = MUL_B_W'(in_q.meas_x);
        base = ACC_W'({1'b0, sum_r_q});
      end
      OP_R_MY: begin op_a = MUL_A_W'(in_q.meas_y); op_b = MUL_B_W'(in_q.meas_y); end
      OP_C_MX: begin
        op_a = MUL_A_W'(in_q.meas_x); op_b = MUL_B_W'(by);
        base = ACC_W'(sum_c_q);
      end
      OP_C_MY: begin
        op_a = MUL_A_W'(in_q.meas_y); op_b = MUL_B_W'(bx); op_sub = 1'b1;
      end
      OP_D_NR: begin op_a = MUL_A_W'({1'b0, sum_r_q}); op_b = n_b; base = '0; end
      OP_D_SX: begin op_a = MUL_A_W'(sum_mx_q); op_b = MUL_B_W'(sum_mx_q); op_sub = 1'b1; end
      OP_D_SY: begin op_a = MUL_A_W'(sum_my_q); op_b = MUL_B_W'(sum_my_q); op_sub = 1'b1; end
      OP_N_NC: begin op_a = MUL_A_W'(sum_c_q); op_b = n_b; base = '0; end
      OP_N_SY: begin op_a = MUL_A_W'(sum_my_q); op_b = MUL_B_W'(sum_bx_q); end
      OP_N_SX: begin op_a = MUL_A_W'(sum_mx_q); op_b = MUL_B_W'(sum_by_q); op_sub = 1'b1; end
      OP_DX: begin
        op_a = MUL_A_W'(sum_my_q); op_b = MUL_B_W'(dt_q);
        base = ACC_W'(sum_bx_q) <<< 16;
      end
      OP_DY: begin
        op_a = MUL_A_W'(sum_mx_q); op_b = MUL_B_W'(dt_q); op_sub = 1'b1;
        base = ACC_W'(sum_by_q) <<< 16;
      end
      OP_X_C: begin
        op_a = dxq_q; op_b = MUL_B_W'(in_q.pose_cos);
        base = ACC_W'(in_q.pose_x) <<< 30;
      end
      OP_X_S: begin op_a = dyq_q; op_b = MUL_B_W'(in_q.pose_sin); op_sub = 1'b1; end
      OP_Y_S: begin
        op_a = dxq_q; op_b = MUL_B_W'(in_q.pose_sin);
        base = ACC_W'(in_q.pose_y) <<< 30;
      end
      OP_Y_C: begin op_a = dyq_q; op_b = MUL_B_W'(in_q.pose_cos); end
      default: begin end
    endcase
  end

  assign prod  = op_a * op_b;
  assign acc_d = op_sub ? (base - mul_q) : (base + mul_q);

  // Dividend: magnitude of the accumulator (shifted up 16 bits for the heading) plus half the divisor
  assign acc_mag = acc_q[ACC_W-1] ? 64'(-acc_q) : 64'(acc_q);
  assign dvd = (op_q == OP_N_SX) ? ((acc_mag << 16) + 64'(den_q >> 1))
                                 : (acc_mag + 64'(cnt_q >> 1));
  assign trial = {1'b0, rem_q[47:0], quo_q[63]} - {2'b00, den_q};

  // Quotient with sign, and clamped heading step
  assign quo_s = neg_q ? -$signed(quo_q) : $signed(quo_q);
  always_comb begin
    if (neg_q) begin
      dt_sat = (quo_q > DT_NEG_LIM) ? DT_W'(-64'sd262144) : DT_W'(quo_s);
    end else begin
      dt_sat = (quo_q > DT_POS_LIM) ? DT_W'(64'sd262143) : DT_W'(quo_s);
    end
  end

  // Round half away from zero by 2^30, then clamp to 16 bits
  assign rnd_sum = acc_q + (acc_q[ACC_W-1] ? RND_HALF_M : RND_HALF);
  assign rnd_q   = 34'(rnd_sum >>> 30);
  always_comb begin
    if (rnd_q > 34'sd32767) begin
      rnd_sat = 16'sh7fff;
    end else if (rnd_q < -34'sd32768) begin
      rnd_sat = -16'sh8000;
    end else begin
      rnd_sat = 16'(rnd_q);
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_R_MX;
      cnt_q     <= '0;
      sum_mx_q  <= '0;
      sum_my_q  <= '0;
      sum_bx_q  <= '0;
      sum_by_q  <= '0;
      sum_r_q   <= '0;
      sum_c_q   <= '0;
      max_err_q <= '0;
      m_valid_q <= 1'b0;
      last_q    <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      // Result taken; a new one from ST_DONE is loaded below
      if (m_valid_q && m_axis_tready && state_q != ST_DONE) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            in_q   <= in_w;
            last_q <= s_axis_tlast;
            if (take) begin
              cnt_q    <= cnt_q + 1'b1;
              sum_mx_q <= sum_mx_q + 24'(in_w.meas_x);
              sum_my_q <= sum_my_q + 24'(in_w.meas_y);
              sum_bx_q <= sum_bx_q + 24'(17'(in_w.nom_x) - 17'(in_w.meas_x));
              sum_by_q <= sum_by_q + 24'(17'(in_w.nom_y) - 17'(in_w.meas_y));
              if (in_w.pair_error > max_err_q) begin
                max_err_q <= in_w.pair_error;
              end
              op_q    <= OP_R_MX;
              state_q <= ST_MUL;
            end else begin
              state_q <= ST_CHK;
            end
          end
        end
        ST_MUL: begin
          mul_q   <= ACC_W'(prod);
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          acc_q <= acc_d;
          case (op_q)
            OP_R_MY: begin
              sum_r_q <= acc_d[39:0];
              op_q    <= op_q + 1'b1;
              state_q <= ST_MUL;
            end
            OP_C_MY: begin
              sum_c_q <= acc_d[41:0];
              state_q <= ST_CHK;
            end
            OP_D_SY: begin
              den_q <= acc_d[DEN_W-1:0];
              op_q  <= op_q + 1'b1;
              if (acc_d[ACC_W-1] || acc_d == '0) begin
                stat_q  <= STATUS_SINGULAR;
                nx_q    <= in_q.pose_x;
                ny_q    <= in_q.pose_y;
                dt_q    <= '0;
                state_q <= ST_DONE;
              end else begin
                state_q <= ST_MUL;
              end
            end
            OP_N_SX, OP_DX, OP_DY: begin
              state_q <= ST_PREP;
            end
            OP_X_S, OP_Y_C: begin
              state_q <= ST_DEND;
            end
            default: begin
              op_q    <= op_q + 1'b1;
              state_q <= ST_MUL;
            end
          endcase
        end
        ST_CHK: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (few) begin
            stat_q  <= STATUS_FEW;
            nx_q    <= in_q.pose_x;
            ny_q    <= in_q.pose_y;
            dt_q    <= '0;
            state_q <= ST_DONE;
          end else begin
            op_q    <= OP_D_NR;
            state_q <= ST_MUL;
          end
        end
        ST_PREP: begin
          neg_q     <= acc_q[ACC_W-1];
          quo_q     <= dvd;
          rem_q     <= '0;
          div_cnt_q <= '0;
          if (op_q != OP_N_SX) begin
            den_q <= DEN_W'(cnt_q);
          end
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          // One quotient bit per cycle
          if (!trial[49]) begin
            rem_q <= trial[48:0];
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= {rem_q[47:0], quo_q[63]};
            quo_q <= {quo_q[62:0], 1'b0};
          end
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 6'd63) begin
            state_q <= ST_DEND;
          end
        end
        ST_DEND: begin
          case (op_q)
            OP_N_SX: begin
              dt_q    <= dt_sat;
              op_q    <= op_q + 1'b1;
              state_q <= ST_MUL;
            end
            OP_DX: begin
              dxq_q   <= 48'(quo_s);
              op_q    <= op_q + 1'b1;
              state_q <= ST_MUL;
            end
            OP_DY: begin
              dyq_q   <= 48'(quo_s);
              op_q    <= op_q + 1'b1;
              state_q <= ST_MUL;
            end
            OP_X_S: begin
              nx_q    <= rnd_sat;
              op_q    <= op_q + 1'b1;
              state_q <= ST_MUL;
            end
            OP_Y_C: begin
              ny_q    <= rnd_sat;
              stat_q  <= STATUS_OK;
              state_q <= ST_DONE;
            end
            default: begin
              op_q    <= op_q + 1'b1;
              state_q <= ST_MUL;
            end
          endcase
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q              <= 1'b1;
            m_user_q               <= stat_q;
            m_data_q.pad           <= '0;
            m_data_q.max_error     <= max_err_q;
            m_data_q.delta_heading <= dt_q;
            m_data_q.new_y         <= ny_q;
            m_data_q.new_x         <= nx_q;
            cnt_q     <= '0;
            sum_mx_q  <= '0;
            sum_my_q  <= '0;
            sum_bx_q  <= '0;
            sum_by_q  <= '0;
            sum_r_q   <= '0;
            sum_c_q   <= '0;
            max_err_q <= '0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== design/lspc_checker.sv =====
`timescale 1ns / 1ps
module lspc_checker
  import lspc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  out_data_t od;
  assign od = out_data_t'(m_axis_tdata);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Every pair keeps the block busy for at least the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // A failed fit gives no heading correction
  a_fail_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STATUS_OK |-> od.delta_heading == '0)
    else $error("nonzero heading on failed fit");

  // Padding bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> od.pad == '0)
    else $error("pad bits set");

endmodule

bind least_squares_pose_correction_unit lspc_checker u_lspc_checker (.*);

// ===== test/least_squares_pose_correction_unit_tb.sv =====
`timescale 1ns / 1ps

module least_squares_pose_correction_unit_tb;
  import lspc_pkg::*;

  localparam int MAX_PAIRS = 64;
  localparam int MIN_PAIRS = 4;
  localparam longint Q30 = 64'sd1073741824;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] new_x;
    logic [15:0] new_y;
    logic [18:0] dheading;
    logic [15:0] max_err;
  } correction_t;

  // Golden model of the pose fit plus the queue of pending corrections
  class pose_fit_board;
    longint n, smx, smy, srad, sbx, sby, scross, emax;
    correction_t pending[$];
    int errors;

    function void clear_sums();
      n = 0; smx = 0; smy = 0; srad = 0; sbx = 0; sby = 0; scross = 0; emax = 0;
    endfunction

    function longint rdiv(longint num, longint den);
      longint q;
      q = ((num < 0 ? -num : num) + den / 2) / den;
      return num < 0 ? -q : q;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Note one accepted pair
    function void add_pair(in_data_t p, logic last);
      longint mx, my, bx, by, d, num, dt, dxq, dyq, px, py, pc, ps, nx, ny;
      correction_t c;
      mx = p.meas_x; my = p.meas_y;
      if (n < MAX_PAIRS) begin
        bx = longint'(p.nom_x) - mx;
        by = longint'(p.nom_y) - my;
        n++; smx += mx; smy += my; srad += mx * mx + my * my;
        sbx += bx; sby += by; scross += mx * by - my * bx;
        if (p.pair_error > emax) emax = p.pair_error;
      end
      if (!last) return;
      px = p.pose_x; py = p.pose_y; pc = p.pose_cos; ps = p.pose_sin;
      nx = px; ny = py; dt = 0; c.status = STATUS_OK;
      if (n < MIN_PAIRS) begin
        c.status = STATUS_FEW;
      end else begin
        d = n * srad - smx * smx - smy * smy;
        if (d <= 0) begin
          c.status = STATUS_SINGULAR;
        end else begin
          num = n * scross + smy * sbx - smx * sby;
          dt = sat(rdiv(num * 65536, d), -262144, 262143);
          dxq = rdiv(sbx * 65536 + smy * dt, n);
          dyq = rdiv(sby * 65536 - smx * dt, n);
          nx = sat(rdiv(px * Q30 + pc * dxq - ps * dyq, Q30), -32768, 32767);
          ny = sat(rdiv(py * Q30 + ps * dxq + pc * dyq, Q30), -32768, 32767);
        end
      end
      c.new_x = nx[15:0]; c.new_y = ny[15:0]; c.dheading = dt[18:0];
      c.max_err = emax[15:0];
      pending = {pending, c};
      clear_sums();
    endfunction

    // Compare one output transfer with the oldest pending correction
    function void check_result(logic [1:0] st, out_data_t o);
      correction_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status %0d data %h", $time, st, o);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, st); errors++;
      end
      if (o.new_x !== e.new_x) begin
        $display("%0t: new_x exp %h got %h", $time, e.new_x, o.new_x); errors++;
      end
      if (o.new_y !== e.new_y) begin
        $display("%0t: new_y exp %h got %h", $time, e.new_y, o.new_y); errors++;
      end
      if (o.delta_heading !== e.dheading) begin
        $display("%0t: delta_heading exp %h got %h", $time, e.dheading, o.delta_heading);
        errors++;
      end
      if (o.max_error !== e.max_err) begin
        $display("%0t: max_error exp %h got %h", $time, e.max_err, o.max_error); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  pose_fit_board board = new();
  int src_idle_pct = 19;
  int snk_idle_pct = 84;
  int sent_pairs;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  least_squares_pose_correction_unit #(
    .MAX_PAIRS(MAX_PAIRS),
    .MIN_PAIRS(MIN_PAIRS)
  ) u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Receiver: random stalls, check on each output transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tuser, m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Send one pair; random idle cycles ahead of it, valid drops only while idling
  task automatic send_pair(in_data_t p, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.add_pair(p, last);
    sent_pairs++;
  endtask

  function automatic logic [15:0] rnd16(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(400)) - 200);
      default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  function automatic in_data_t rand_pair(int spread);
    in_data_t p;
    int c;
    p.meas_x = rnd16(spread); p.meas_y = rnd16(spread);
    p.nom_x = p.meas_x + 16'($signed($urandom_range(60)) - 30);
    p.nom_y = p.meas_y + 16'($signed($urandom_range(60)) - 30);
    if ($urandom_range(9) == 0) begin
      p.nom_x = 16'($urandom); p.nom_y = 16'($urandom);
    end
    p.pair_error = 16'($urandom);
    p.pose_x = 16'($urandom); p.pose_y = 16'($urandom);
    c = $urandom_range(4);
    p.pose_cos = c == 0 ? 16'sh4000 :
                 (c == 1 ? -16'sh4000 : 16'($signed($urandom_range(32768)) - 16384));
    p.pose_sin = c < 2 ? 16'sh0 : 16'($signed($urandom_range(32768)) - 16384);
    return p;
  endfunction

  // One set of pairs; last flag on the final one
  task automatic send_set(int count, int spread, bit same_point);
    in_data_t p, first;
    for (int i = 0; i < count; i++) begin
      p = rand_pair(spread);
      if (i == 0) first = p;
      if (same_point) begin
        p.meas_x = first.meas_x; p.meas_y = first.meas_y;
      end
      send_pair(p, i == count - 1);
    end
  endtask

  task automatic random_phase(int pairs);
    int target;
    target = sent_pairs + pairs;
    while (sent_pairs < target) begin
      case ($urandom_range(19))
        0: send_set($urandom_range(1, 3), $urandom_range(1), 0);
        1: send_set($urandom_range(4, 8), $urandom_range(1), 1);
        2: send_set($urandom_range(60, 70), 0, 0);
        3: send_set($urandom_range(4, 10), 2, 0);
        default: send_set($urandom_range(4, 12), $urandom_range(1), 0);
      endcase
    end
  endtask

  initial begin
    in_data_t p;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: lone last pair, extremes, coincident points, small sets
    p = '0;
    send_pair(p, 1'b1);
    p.meas_x = 16'sh7fff; p.meas_y = 16'sh8000; p.nom_x = 16'sh8000; p.nom_y = 16'sh7fff;
    p.pair_error = 16'hffff; p.pose_x = 16'sh7fff; p.pose_y = 16'sh8000;
    p.pose_cos = 16'sh4000; p.pose_sin = -16'sh4000;
    send_pair(p, 1'b0);
    p.meas_x = 16'sh8000; p.meas_y = 16'sh7fff; p.nom_x = 16'sh7fff; p.nom_y = 16'sh8000;
    send_pair(p, 1'b0);
    p.meas_x = 16'sh0; p.meas_y = 16'sh8000; p.pair_error = 16'h0;
    send_pair(p, 1'b0);
    p.meas_x = 16'sh7fff; p.meas_y = 16'sh0; p.pose_sin = 16'sh4000; p.pose_cos = 16'sh0;
    send_pair(p, 1'b1);
    send_set(5, 1, 1);
    send_set(4, 1, 0);
    send_set(3, 1, 0);
    send_set(2, 2, 0);

    random_phase(450);
    src_idle_pct = 84; snk_idle_pct = 19;
    random_phase(450);
    src_idle_pct = 0; snk_idle_pct = 0;
    random_phase(400);
    s_axis_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
